/* sv/wlm_pkg.sv */
// Shared types and constants for the weekly alarm match table.
// Holds the command codes, status codes, entry layout and compare structs.
// No dependencies.
`default_nettype none

package wlm_pkg;

    // Command codes carried on the input channel
    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_MARK   = 2'd3
    } cmd_t;

    // Status codes carried on the result channel
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_NOT_SYNC = 2'd2;

    // Last minute register value meaning no minute seen yet
    localparam logic [6:0] MINUTE_NONE = 7'd127;

    // One stored alarm entry, 27 bits
    typedef struct packed {
        logic       enabled;
        logic [6:0] day_mask;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [7:0] module_id;
    } entry_t;

    // Search key presented to the compare unit
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [2:0] day_of_week;
        logic [7:0] module_id;
    } key_t;

    // Compare unit results
    typedef struct packed {
        logic due;
        logic key_hit;
    } match_t;

endpackage

`default_nettype wire

/* sv/weekly_alarm_match_table.sv */
// Top level of the weekly alarm match table: command sequencer, handled
// flags and result register. Uses wlm_pkg, wlm_entry_ram and wlm_match.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | cmd, hour, minute, day_of_week, time_synced,
//          |           |                    | module_id, day_mask, entry_enabled
//  m_      | out       | m_valid / m_ready  | status, pending, pending_index/module/hour/
//          |           |                    | minute/day_mask, entry_count
//
// Append, clear and an unsynced check go from accept straight to the done state. A synced
// check or a mark handled scans the used entries one a cycle through the single read
// port and the shared compare unit; a check stops at its first due, unhandled entry.
// Reset clears the entry count and handled flags and sets the last minute seen to
// MINUTE_NONE. s_ready is low while a transaction is in work; a finished result
// waits in the output register while m_ready is low, and the next transaction is taken.
`default_nettype none

module weekly_alarm_match_table #(
    parameter int ENTRIES = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_cmd,
    input  wire logic [4:0] s_hour,
    input  wire logic [5:0] s_minute,
    input  wire logic [2:0] s_day_of_week,
    input  wire logic       s_time_synced,
    input  wire logic [7:0] s_module_id,
    input  wire logic [6:0] s_day_mask,
    input  wire logic       s_entry_enabled,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_status,
    output logic            m_pending,
    output logic [3:0]      m_pending_index,
    output logic [7:0]      m_pending_module,
    output logic [4:0]      m_pending_hour,
    output logic [5:0]      m_pending_minute,
    output logic [6:0]      m_pending_day_mask,
    output logic [4:0]      m_entry_count
);

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    wlm_pkg::cmd_t       cmd_reg, cmd_next, s_cmd_code;
    wlm_pkg::key_t       key_reg, key_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic                eval_vld_reg, eval_vld_next;
    logic [IW-1:0]       eval_idx_reg, eval_idx_next;
    logic [ENTRIES-1:0]  flags_reg, flags_next;
    logic [6:0]          last_min_reg, last_min_next;
    logic [1:0]          status_reg, status_next;
    logic                hit_reg, hit_next;
    logic [IW-1:0]       hit_idx_reg, hit_idx_next;
    wlm_pkg::entry_t     hit_entry_reg, hit_entry_next;

    logic                m_valid_reg, m_valid_next;
    logic [1:0]          m_status_reg, m_status_next;
    logic                m_pending_reg, m_pending_next;
    logic [IW-1:0]       m_index_reg, m_index_next;
    wlm_pkg::entry_t     m_entry_reg, m_entry_next;
    logic [CW-1:0]       m_count_reg, m_count_next;

    logic                accept;
    logic                wr_en;
    wlm_pkg::entry_t     wr_data;
    logic                rd_en;
    wlm_pkg::entry_t     rd_data;
    wlm_pkg::match_t     match;
    logic                hit_now;
    logic [IW+3:0]       index_ext;
    logic [CW+4:0]       count_ext;

    assign s_cmd_code = wlm_pkg::cmd_t'(s_cmd);
    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;

    // Append writes the next free slot in the accept cycle
    assign wr_en = accept && (s_cmd_code == wlm_pkg::CMD_APPEND) && (count_reg < FULL_COUNT);
    assign wr_data.enabled   = s_entry_enabled;
    assign wr_data.day_mask  = s_day_mask;
    assign wr_data.minute    = s_minute;
    assign wr_data.hour      = s_hour;
    assign wr_data.module_id = s_module_id;

    wlm_entry_ram #(
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    wlm_match u_match (
        .entry  (rd_data),
        .key    (key_reg),
        .result (match)
    );

    // First due, unhandled entry of a check stops the scan
    assign hit_now = (state_reg == ST_SCAN) && eval_vld_reg
                     && (cmd_reg == wlm_pkg::CMD_CHECK)
                     && match.due && !flags_reg[eval_idx_reg];
    assign rd_en   = (state_reg == ST_SCAN) && (ptr_reg < count_reg) && !hit_now;

    // Sequencer next state
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        eval_vld_next  = 1'b0;
        eval_idx_next  = eval_idx_reg;
        flags_next     = flags_reg;
        last_min_next  = last_min_reg;
        status_next    = status_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_entry_next = hit_entry_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_pending_next = m_pending_reg;
        m_index_next   = m_index_reg;
        m_entry_next   = m_entry_reg;
        m_count_next   = m_count_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next              = s_cmd_code;
                    key_next.hour         = s_hour;
                    key_next.minute       = s_minute;
                    key_next.day_of_week  = s_day_of_week;
                    key_next.module_id    = s_module_id;
                    ptr_next              = '0;
                    status_next           = wlm_pkg::STATUS_OK;
                    hit_next              = 1'b0;
                    hit_idx_next          = '0;
                    hit_entry_next        = '0;
                    state_next            = ST_DONE;
                    case (s_cmd_code)
                        wlm_pkg::CMD_APPEND: begin
                            if (count_reg < FULL_COUNT) begin
                                count_next = count_reg + CW'(1);
                            end else begin
                                status_next = wlm_pkg::STATUS_FULL;
                            end
                        end
                        wlm_pkg::CMD_CLEAR: begin
                            count_next = '0;
                        end
                        wlm_pkg::CMD_CHECK: begin
                            if (!s_time_synced) begin
                                status_next = wlm_pkg::STATUS_NOT_SYNC;
                            end else begin
                                // New minute drops every handled flag
                                if ({1'b0, s_minute} != last_min_reg) begin
                                    last_min_next = {1'b0, s_minute};
                                    flags_next    = '0;
                                end
                                state_next = ST_SCAN;
                            end
                        end
                        wlm_pkg::CMD_MARK: begin
                            state_next = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // Issue the next read, evaluate the one returned
                if (rd_en) begin
                    ptr_next      = ptr_reg + CW'(1);
                    eval_vld_next = 1'b1;
                    eval_idx_next = ptr_reg[IW-1:0];
                end
                if (eval_vld_reg && (cmd_reg == wlm_pkg::CMD_MARK) && match.key_hit) begin
                    flags_next[eval_idx_reg] = 1'b1;
                end
                if (hit_now) begin
                    hit_next       = 1'b1;
                    hit_idx_next   = eval_idx_reg;
                    hit_entry_next = rd_data;
                    state_next     = ST_DONE;
                end else if (!rd_en && !eval_vld_reg) begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = status_reg;
                    m_pending_next = hit_reg;
                    m_index_next   = hit_idx_reg;
                    m_entry_next   = hit_entry_reg;
                    m_count_next   = count_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            eval_vld_reg <= 1'b0;
            flags_reg    <= '0;
            last_min_reg <= wlm_pkg::MINUTE_NONE;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            eval_vld_reg <= eval_vld_next;
            flags_reg    <= flags_next;
            last_min_reg <= last_min_next;
            m_valid_reg  <= m_valid_next;
        end
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        ptr_reg       <= ptr_next;
        eval_idx_reg  <= eval_idx_next;
        status_reg    <= status_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        hit_entry_reg <= hit_entry_next;
        m_status_reg  <= m_status_next;
        m_pending_reg <= m_pending_next;
        m_index_reg   <= m_index_next;
        m_entry_reg   <= m_entry_next;
        m_count_reg   <= m_count_next;
    end

    // Fit index and count to the port widths
    assign index_ext = {4'b0, m_index_reg};
    assign count_ext = {5'b0, m_count_reg};

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_pending          = m_pending_reg;
    assign m_pending_index    = index_ext[3:0];
    assign m_pending_module   = m_entry_reg.module_id;
    assign m_pending_hour     = m_entry_reg.hour;
    assign m_pending_minute   = m_entry_reg.minute;
    assign m_pending_day_mask = m_entry_reg.day_mask;
    assign m_entry_count      = count_ext[4:0];

endmodule

`default_nettype wire

/* sv/wlm_entry_ram.sv */
// Entry storage for the weekly alarm match table: one write port, one
// registered read port. Depends on wlm_pkg for the entry layout.
`default_nettype none

module wlm_entry_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic            aclk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire wlm_pkg::entry_t wr_data,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output wlm_pkg::entry_t      rd_data
);

    wlm_pkg::entry_t mem [DEPTH];
    wlm_pkg::entry_t rd_data_reg;

    // Write on append, read on scan
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/wlm_match.sv */
// Shared compare unit: tests one stored entry against the search key.
// Depends on wlm_pkg for entry, key and result structs.
`default_nettype none

module wlm_match (
    input  wire wlm_pkg::entry_t entry,
    input  wire wlm_pkg::key_t   key,
    output wlm_pkg::match_t      result
);

    logic       time_hit;
    logic [7:0] mask_ext;

    // Weekday seven falls on the padding bit and never matches
    assign mask_ext = {1'b0, entry.day_mask};
    assign time_hit = (entry.hour == key.hour) && (entry.minute == key.minute);

    assign result.due     = entry.enabled && time_hit && mask_ext[key.day_of_week];
    assign result.key_hit = time_hit && (entry.module_id == key.module_id);

endmodule

`default_nettype wire

/* test/weekly_alarm_match_table_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for weekly_alarm_match_table: directed and random command
// streams with a scoreboard that keeps its own copy of the alarm table.
// Depends on wlm_pkg and the weekly_alarm_match_table RTL.

localparam int TABLE_SLOTS = 16;

// One result transaction as seen on the m_ channel
typedef struct packed {
    logic [1:0] status;
    logic       pending;
    logic [3:0] index;
    logic [7:0] module_id;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] day_mask;
    logic [4:0] entry_count;
} alarm_result_t;

class alarm_table_scoreboard;
    wlm_pkg::entry_t alarm_slots[TABLE_SLOTS];
    bit              handled[TABLE_SLOTS];
    int unsigned     used_slots;
    logic [6:0]      last_minute;
    alarm_result_t   awaited[$];
    int unsigned     mismatches;
    int unsigned     results_seen;
    int unsigned     hits_seen;
    int unsigned     full_refusals;
    int unsigned     unsynced_checks;

    function new();
        foreach (alarm_slots[i]) alarm_slots[i] = '0;
        foreach (handled[i]) handled[i] = 1'b0;
        used_slots      = 0;
        last_minute     = wlm_pkg::MINUTE_NONE;
        mismatches      = 0;
        results_seen    = 0;
        hits_seen       = 0;
        full_refusals   = 0;
        unsynced_checks = 0;
    endfunction

    // Apply one accepted command to the table copy and queue its result
    function void note_command(wlm_pkg::cmd_t op, logic [4:0] hr, logic [5:0] mn,
                               logic [2:0] dow, logic synced, logic [7:0] mod,
                               logic [6:0] mask, logic en);
        alarm_result_t res;
        logic [7:0]    day_bits;
        bit            hit;
        res = '0;
        hit = 1'b0;
        case (op)
            wlm_pkg::CMD_APPEND: begin
                if (used_slots >= TABLE_SLOTS) begin
                    res.status = wlm_pkg::STATUS_FULL;
                    full_refusals++;
                end else begin
                    alarm_slots[used_slots] = '{enabled: en, day_mask: mask, minute: mn,
                                                hour: hr, module_id: mod};
                    used_slots++;
                end
            end
            wlm_pkg::CMD_CLEAR: begin
                // handled flags are kept on purpose
                foreach (alarm_slots[i]) alarm_slots[i] = '0;
                used_slots = 0;
            end
            wlm_pkg::CMD_CHECK: begin
                if (!synced) begin
                    res.status = wlm_pkg::STATUS_NOT_SYNC;
                    unsynced_checks++;
                end else begin
                    // a new minute releases every handled flag
                    if ({1'b0, mn} != last_minute) begin
                        last_minute = {1'b0, mn};
                        foreach (handled[i]) handled[i] = 1'b0;
                    end
                    // lowest enabled, unhandled slot matching time and weekday wins
                    for (int i = 0; i < used_slots && !hit; i++) begin
                        day_bits = {1'b0, alarm_slots[i].day_mask} >> dow;
                        if (alarm_slots[i].enabled && !handled[i] &&
                            alarm_slots[i].hour == hr && alarm_slots[i].minute == mn &&
                            day_bits[0]) begin
                            hit             = 1'b1;
                            res.pending     = 1'b1;
                            res.index       = 4'(i);
                            res.module_id   = alarm_slots[i].module_id;
                            res.hour        = alarm_slots[i].hour;
                            res.minute      = alarm_slots[i].minute;
                            res.day_mask    = alarm_slots[i].day_mask;
                        end
                    end
                    if (hit) hits_seen++;
                end
            end
            wlm_pkg::CMD_MARK: begin
                // enable bit plays no part in the key match
                for (int i = 0; i < used_slots; i++) begin
                    if (alarm_slots[i].module_id == mod && alarm_slots[i].hour == hr &&
                        alarm_slots[i].minute == mn)
                        handled[i] = 1'b1;
                end
            end
            default: ;
        endcase
        res.entry_count = 5'(used_slots);
        awaited.push_back(res);
    endfunction

    function void compare_field(string name, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endfunction

    // Match one result transaction against the oldest outstanding prediction
    function void check_result(alarm_result_t got);
        alarm_result_t want;
        if (awaited.size() == 0) begin
            $display("%0t: result with nothing outstanding, expected none, actual %p",
                     $time, got);
            mismatches++;
            return;
        end
        want = awaited.pop_front();
        results_seen++;
        compare_field("status", want.status, got.status);
        compare_field("pending", want.pending, got.pending);
        compare_field("pending_index", want.index, got.index);
        compare_field("pending_module", want.module_id, got.module_id);
        compare_field("pending_hour", want.hour, got.hour);
        compare_field("pending_minute", want.minute, got.minute);
        compare_field("pending_day_mask", want.day_mask, got.day_mask);
        compare_field("entry_count", want.entry_count, got.entry_count);
    endfunction
endclass

module weekly_alarm_match_table_tb;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_ITEMS  = 200;
    localparam int SETTLE_CYCLES = 40;

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic [1:0] s_cmd           = '0;
    logic [4:0] s_hour          = '0;
    logic [5:0] s_minute        = '0;
    logic [2:0] s_day_of_week   = '0;
    logic       s_time_synced   = 1'b0;
    logic [7:0] s_module_id     = '0;
    logic [6:0] s_day_mask      = '0;
    logic       s_entry_enabled = 1'b0;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic [1:0] m_status;
    logic       m_pending;
    logic [3:0] m_pending_index;
    logic [7:0] m_pending_module;
    logic [4:0] m_pending_hour;
    logic [5:0] m_pending_minute;
    logic [6:0] m_pending_day_mask;
    logic [4:0] m_entry_count;

    alarm_table_scoreboard sb;
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int items_sent        = 0;
    int cycle_count       = 0;

    weekly_alarm_match_table #(
        .ENTRIES(TABLE_SLOTS)
    ) u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_hour             (s_hour),
        .s_minute           (s_minute),
        .s_day_of_week      (s_day_of_week),
        .s_time_synced      (s_time_synced),
        .s_module_id        (s_module_id),
        .s_day_mask         (s_day_mask),
        .s_entry_enabled    (s_entry_enabled),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_pending          (m_pending),
        .m_pending_index    (m_pending_index),
        .m_pending_module   (m_pending_module),
        .m_pending_hour     (m_pending_hour),
        .m_pending_minute   (m_pending_minute),
        .m_pending_day_mask (m_pending_day_mask),
        .m_entry_count      (m_entry_count)
    );

    always #1 aclk = ~aclk;

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Check every result transaction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{status: m_status, pending: m_pending, index: m_pending_index,
                              module_id: m_pending_module, hour: m_pending_hour,
                              minute: m_pending_minute, day_mask: m_pending_day_mask,
                              entry_count: m_entry_count});
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("weekly_alarm_match_table regression: fail");
            $finish;
        end
    end

    // Present one command, hold it until accepted, then log it
    task automatic send_cmd(wlm_pkg::cmd_t op, logic [4:0] hr, logic [5:0] mn,
                            logic [2:0] dow, logic synced, logic [7:0] mod,
                            logic [6:0] mask, logic en);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_cmd           <= op;
        s_hour          <= hr;
        s_minute        <= mn;
        s_day_of_week   <= dow;
        s_time_synced   <= synced;
        s_module_id     <= mod;
        s_day_mask      <= mask;
        s_entry_enabled <= en;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_command(op, hr, mn, dow, synced, mod, mask, en);
        items_sent++;
        @(negedge aclk);
    endtask

    // Hold off the sender until every outstanding result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.awaited.size() != 0) @(negedge aclk);
    endtask

    // Fill the table from a small pool of times, then hit it with checks and marks
    task automatic run_episode();
        logic [4:0] hours[3];
        logic [5:0] minutes[3];
        logic [7:0] mods[3];
        int         pick;
        int         roll;
        for (int i = 0; i < 3; i++) begin
            if ($urandom_range(9) == 0) begin
                hours[i]   = 5'($urandom);
                minutes[i] = 6'($urandom);
            end else begin
                hours[i]   = 5'($urandom_range(23));
                minutes[i] = 6'($urandom_range(59));
            end
            mods[i] = 8'($urandom);
        end
        if ($urandom_range(9) < 7)
            send_cmd(wlm_pkg::CMD_CLEAR, 5'($urandom), 6'($urandom), 3'($urandom),
                     1'($urandom), 8'($urandom), 7'($urandom), 1'($urandom));
        repeat ($urandom_range(1, 20)) begin
            pick = $urandom_range(2);
            send_cmd(wlm_pkg::CMD_APPEND, hours[pick], minutes[pick], 3'($urandom),
                     1'($urandom), mods[$urandom_range(2)],
                     ($urandom_range(3) == 0) ? 7'h7F : 7'($urandom),
                     $urandom_range(4) != 0);
        end
        repeat ($urandom_range(6, 16)) begin
            pick = $urandom_range(2);
            roll = $urandom_range(99);
            if (roll < 50)
                send_cmd(wlm_pkg::CMD_CHECK, hours[pick], minutes[pick], 3'($urandom),
                         $urandom_range(9) != 0, 8'($urandom), 7'($urandom), 1'($urandom));
            else if (roll < 75)
                send_cmd(wlm_pkg::CMD_MARK, hours[pick], minutes[pick], 3'($urandom),
                         1'($urandom), mods[$urandom_range(2)], 7'($urandom),
                         1'($urandom));
            else if (roll < 88)
                send_cmd(wlm_pkg::cmd_t'($urandom_range(3)), 5'($urandom), 6'($urandom),
                         3'($urandom), 1'($urandom), 8'($urandom), 7'($urandom),
                         1'($urandom));
            else if (roll < 96)
                send_cmd(wlm_pkg::CMD_APPEND, hours[pick], minutes[pick], 3'($urandom),
                         1'($urandom), mods[$urandom_range(2)], 7'($urandom),
                         $urandom_range(4) != 0);
            else if (roll < 98)
                send_cmd(wlm_pkg::CMD_CLEAR, 5'($urandom), 6'($urandom), 3'($urandom),
                         1'($urandom), 8'($urandom), 7'($urandom), 1'($urandom));
            else
                drain_results();
        end
    endtask

    task automatic run_phase(int send_idle, int recv_idle, int target);
        int start_count;
        sender_idle_pct   = send_idle;
        receiver_idle_pct = recv_idle;
        start_count       = items_sent;
        while (items_sent - start_count < target) run_episode();
        drain_results();
    endtask

    initial begin
        sb = new();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // check an empty table, synced and unsynced
        send_cmd(wlm_pkg::CMD_CHECK,  5'd0,  6'd0,  3'd0, 1'b1, 8'h00, 7'h00, 1'b0);
        send_cmd(wlm_pkg::CMD_CHECK,  5'd0,  6'd0,  3'd0, 1'b0, 8'h00, 7'h00, 1'b0);
        // load extremes: full mask, empty mask, disabled, one weekday, out of range time
        send_cmd(wlm_pkg::CMD_APPEND, 5'd23, 6'd59, 3'd0, 1'b0, 8'hFF, 7'h7F, 1'b1);
        send_cmd(wlm_pkg::CMD_APPEND, 5'd0,  6'd0,  3'd7, 1'b1, 8'h00, 7'h00, 1'b1);
        send_cmd(wlm_pkg::CMD_APPEND, 5'd23, 6'd59, 3'd0, 1'b0, 8'h05, 7'h7F, 1'b0);
        send_cmd(wlm_pkg::CMD_APPEND, 5'd23, 6'd59, 3'd0, 1'b0, 8'h12, 7'h40, 1'b1);
        send_cmd(wlm_pkg::CMD_APPEND, 5'd31, 6'd63, 3'd0, 1'b0, 8'hA5, 7'h7F, 1'b1);
        // due on Sunday, never on weekday seven, refused while unsynced
        send_cmd(wlm_pkg::CMD_CHECK,  5'd23, 6'd59, 3'd0, 1'b1, 8'h00, 7'h00, 1'b0);
        send_cmd(wlm_pkg::CMD_CHECK,  5'd23, 6'd59, 3'd7, 1'b1, 8'h00, 7'h00, 1'b0);
        send_cmd(wlm_pkg::CMD_CHECK,  5'd23, 6'd59, 3'd6, 1'b0, 8'h00, 7'h00, 1'b0);
        // handle the first hit so the Saturday slot comes through
        send_cmd(wlm_pkg::CMD_MARK,   5'd23, 6'd59, 3'd0, 1'b0, 8'hFF, 7'h00, 1'b0);
        send_cmd(wlm_pkg::CMD_CHECK,  5'd23, 6'd59, 3'd6, 1'b1, 8'h00, 7'h00, 1'b0);
        send_cmd(wlm_pkg::CMD_MARK,   5'd23, 6'd59, 3'd0, 1'b0, 8'h05, 7'h00, 1'b0);
        send_cmd(wlm_pkg::CMD_CHECK,  5'd0,  6'd0,  3'd3, 1'b1, 8'h00, 7'h00, 1'b0);
        send_cmd(wlm_pkg::CMD_CHECK,  5'd31, 6'd63, 3'd3, 1'b1, 8'h00, 7'h00, 1'b0);
        // handled flag outlives a clear until the minute moves
        send_cmd(wlm_pkg::CMD_CLEAR,  5'd31, 6'd63, 3'd7, 1'b1, 8'hFF, 7'h7F, 1'b1);
        send_cmd(wlm_pkg::CMD_APPEND, 5'd31, 6'd63, 3'd0, 1'b0, 8'hA5, 7'h7F, 1'b1);
        send_cmd(wlm_pkg::CMD_MARK,   5'd31, 6'd63, 3'd0, 1'b0, 8'hA5, 7'h00, 1'b0);
        send_cmd(wlm_pkg::CMD_CLEAR,  5'd0,  6'd0,  3'd0, 1'b0, 8'h00, 7'h00, 1'b0);
        send_cmd(wlm_pkg::CMD_APPEND, 5'd31, 6'd63, 3'd0, 1'b0, 8'hA5, 7'h7F, 1'b1);
        send_cmd(wlm_pkg::CMD_CHECK,  5'd0,  6'd5,  3'd4, 1'b0, 8'h00, 7'h00, 1'b0);
        send_cmd(wlm_pkg::CMD_CHECK,  5'd31, 6'd63, 3'd4, 1'b1, 8'h00, 7'h00, 1'b0);
        send_cmd(wlm_pkg::CMD_CHECK,  5'd31, 6'd62, 3'd4, 1'b1, 8'h00, 7'h00, 1'b0);
        send_cmd(wlm_pkg::CMD_CHECK,  5'd31, 6'd63, 3'd4, 1'b1, 8'h00, 7'h00, 1'b0);
        drain_results();

        // random traffic under three backpressure profiles
        run_phase(21, 77, PHASE_ITEMS);
        run_phase(77, 21, PHASE_ITEMS);
        run_phase(0, 0, PHASE_ITEMS);

        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("ran %0d commands, checked %0d results: %0d due alarms,", items_sent,
                 sb.results_seen, sb.hits_seen);
        $display("%0d full-table refusals, %0d unsynced checks, %0d results still owed",
                 sb.full_refusals, sb.unsynced_checks, sb.awaited.size());
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("weekly_alarm_match_table regression: pass");
        else
            $display("weekly_alarm_match_table regression: fail");
        $finish;
    end

endmodule
